// ----- src/i2cfw_pkg.sv -----
// Shared constants, codes and control structs for the I2C register slave flash window.
// Used by i2cfw_dp, i2cfw_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package i2cfw_pkg;

    // Sizing
    localparam int BUFFER_BYTES = 128;
    localparam int FLASH_BYTES  = 262144;
    localparam int PAGE_BYTES   = 8192;

    localparam int BUF_WORDS = BUFFER_BYTES / 4;
    localparam int WORD_AW   = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
    localparam int BUF_AW    = $clog2(BUFFER_BYTES);

    localparam logic [31:0] PAGE_MASK      = 32'(PAGE_BYTES - 1);
    localparam logic [31:0] FLASH_LIMIT    = 32'(FLASH_BYTES);
    localparam logic [31:0] WIN_ALIGN_MASK = 32'hFFFF_FF80;
    localparam logic [31:0] WORD_ONES      = 32'hFFFF_FFFF;

    // Bus event codes
    localparam logic [2:0] CMD_MATCH_WR = 3'd0;
    localparam logic [2:0] CMD_MATCH_RD = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;
    localparam logic [2:0] CMD_RESET    = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_PROGRAM = 3'd1;
    localparam logic [2:0] KIND_ERASE   = 3'd2;
    localparam logic [2:0] KIND_UNLOCK  = 3'd3;
    localparam logic [2:0] KIND_LOCK    = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;

    // Register map
    localparam logic [7:0] IDX_BOARD     = 8'h00;
    localparam logic [7:0] IDX_FW        = 8'h01;
    localparam logic [7:0] IDX_PCB       = 8'h02;
    localparam logic [7:0] IDX_DDR       = 8'h03;
    localparam logic [7:0] IDX_BOM       = 8'h04;
    localparam logic [7:0] IDX_CMDBYTE   = 8'h05;
    localparam logic [7:0] IDX_FAMILY    = 8'h18;
    localparam logic [7:0] IDX_LTEMP     = 8'h30;
    localparam logic [7:0] IDX_RTEMP     = 8'h31;
    localparam logic [7:0] IDX_FLASH_CMD = 8'h63;
    localparam logic [7:0] IDX_OFS0      = 8'h7C;
    localparam logic [7:0] IDX_OFS3      = 8'h7F;
    localparam logic [7:0] IDX_WIN       = 8'h80;
    localparam logic [7:0] IDX_FLUSH     = 8'hFF;

    // Flash command bytes written at IDX_FLASH_CMD
    localparam logic [7:0] FOP_UNLOCK = 8'h02;
    localparam logic [7:0] FOP_LOCK   = 8'h03;
    localparam logic [7:0] FOP_ERASE  = 8'h04;

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_BOARD  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_FW     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_PCB    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DDR    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BOM    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_FAMILY = 3'd5;

    // Controller -> datapath
    typedef struct packed {
        logic accept;      // take the input beat and do its byte work
        logic emit_clear;  // send the end-flag clear
        logic fl_rd;       // flush: read buffer word at counter
        logic fl_chk;      // flush: test word, advance counter
        logic fl_end;      // flush: send the held word as last
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic go_clear;    // current beat is a write to the flash command register
        logic go_flush;    // current beat is a stop with flush armed
        logic fl_done;     // counter is on the last buffer word
    } dp_stat_t;

endpackage

// ----- src/i2cfw_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module i2cfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/i2cfw_dp.sv -----
// Datapath: register index, offset bytes, config registers, staging buffer,
// flush word counter and the result register. Uses i2cfw_pkg and i2cfw_ram.
`timescale 1ns / 1ps

module i2cfw_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2cfw_pkg::dp_cmd_t          ctl,
    output i2cfw_pkg::dp_stat_t         stat,
    input  logic [2:0]                  cmd,
    input  logic [7:0]                  data_byte,
    input  logic signed [7:0]           local_temp,
    input  logic signed [7:0]           remote_temp,
    input  logic [7:0]                  flash_byte,
    input  logic                        cfg_we,
    input  logic [i2cfw_pkg::CFG_IW-1:0] cfg_index,
    input  logic [7:0]                  cfg_data,
    output logic                        result_strobe,
    output logic [2:0]                  kind,
    output logic [7:0]                  read_data,
    output logic [31:0]                 target_offset,
    output logic [31:0]                 program_word,
    output logic                        last
);
    import i2cfw_pkg::*;

    // control state
    logic [7:0]              reg_index_reg, reg_index_next;
    logic                    pending_reg, pending_next;
    logic [7:0]              ofs_reg [4];
    logic [7:0]              ofs_next [4];
    logic                    armed_reg, armed_next;
    logic [BUFFER_BYTES-1:0] bvalid_reg, bvalid_next;
    logic [WORD_AW-1:0]      cnt_reg, cnt_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic                    strobe_reg, strobe_next;
    logic [7:0]              cfg_reg [6];

    // payload
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  rd_reg, rd_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic [31:0] hold_word_reg, hold_word_next;
    logic [31:0] hold_off_reg, hold_off_next;
    logic [3:0]  nib_reg, nib_next;

    logic [31:0] offset;
    logic [6:0]  win_k;
    logic        buf_we;
    logic [7:0]  lane_rdata [4];
    logic [31:0] flush_word;
    logic [31:0] flush_addr;

    assign offset = {ofs_reg[0], ofs_reg[1], ofs_reg[2], ofs_reg[3]};
    assign win_k  = reg_index_reg[6:0];
    assign buf_we = ctl.accept && cmd == CMD_WRITE && !pending_reg
                    && reg_index_reg[7] && 32'(win_k) < 32'(BUFFER_BYTES);

    assign stat.go_clear = cmd == CMD_WRITE && !pending_reg && reg_index_reg == IDX_FLASH_CMD;
    assign stat.go_flush = cmd == CMD_STOP && armed_reg;
    assign stat.fl_done  = cnt_reg == WORD_AW'(BUF_WORDS - 1);

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        i2cfw_ram #(
            .WIDTH(8),
            .DEPTH(BUF_WORDS)
        ) u_ram (
            .clk  (clk),
            .we   (buf_we && win_k[1:0] == 2'(l)),
            .waddr(WORD_AW'(win_k >> 2)),
            .wdata(data_byte),
            .re   (ctl.fl_rd),
            .raddr(cnt_reg),
            .rdata(lane_rdata[l])
        );
    end

    // unwritten bytes read as zero
    assign flush_word = {nib_reg[3] ? lane_rdata[3] : 8'h00,
                         nib_reg[2] ? lane_rdata[2] : 8'h00,
                         nib_reg[1] ? lane_rdata[1] : 8'h00,
                         nib_reg[0] ? lane_rdata[0] : 8'h00};
    assign flush_addr = (offset & WIN_ALIGN_MASK) + (32'(cnt_reg) << 2);

    always_comb
    begin
        reg_index_next  = reg_index_reg;
        pending_next    = pending_reg;
        ofs_next        = ofs_reg;
        armed_next      = armed_reg;
        bvalid_next     = bvalid_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_word_next  = hold_word_reg;
        hold_off_next   = hold_off_reg;
        nib_next        = nib_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        rd_next         = 8'h00;
        off_next        = 32'd0;
        word_next       = 32'd0;
        last_next       = 1'b1;

        if (ctl.accept)
        begin
            case (cmd)
                CMD_MATCH_WR:
                begin
                    pending_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    if (pending_reg)
                    begin
                        reg_index_next = data_byte;
                        pending_next   = 1'b0;
                    end
                    else
                    begin
                        reg_index_next = reg_index_reg + 8'd1;
                        if (reg_index_reg == IDX_FLASH_CMD)
                        begin
                            // clear end flag follows from the controller
                            last_next = 1'b0;
                            if (data_byte == FOP_UNLOCK)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_UNLOCK;
                            end
                            else if (data_byte == FOP_LOCK)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_LOCK;
                            end
                            else if (data_byte == FOP_ERASE && (offset & PAGE_MASK) == 32'd0
                                     && offset < FLASH_LIMIT)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_ERASE;
                                off_next    = offset;
                            end
                        end
                        else if (reg_index_reg inside {[IDX_OFS0:IDX_OFS3]})
                        begin
                            ofs_next[reg_index_reg[1:0]] = data_byte;
                        end
                        else if (reg_index_reg[7])
                        begin
                            if (buf_we)
                            begin
                                bvalid_next[win_k[BUF_AW-1:0]] = 1'b1;
                            end
                            if (reg_index_reg == IDX_FLUSH)
                            begin
                                armed_next = 1'b1;
                            end
                        end
                    end
                end
                CMD_READ:
                begin
                    reg_index_next = reg_index_reg + 8'd1;
                    strobe_next    = 1'b1;
                    kind_next      = KIND_READ;
                    case (reg_index_reg)
                        IDX_BOARD:   rd_next = cfg_reg[CFG_BOARD];
                        IDX_FW:      rd_next = cfg_reg[CFG_FW];
                        IDX_PCB:     rd_next = cfg_reg[CFG_PCB];
                        IDX_DDR:     rd_next = cfg_reg[CFG_DDR];
                        IDX_BOM:     rd_next = cfg_reg[CFG_BOM];
                        IDX_CMDBYTE: rd_next = 8'h00;
                        IDX_FAMILY:  rd_next = cfg_reg[CFG_FAMILY];
                        IDX_LTEMP:   rd_next = $unsigned(local_temp);
                        IDX_RTEMP:   rd_next = $unsigned(remote_temp);
                        default:
                        begin
                            if (reg_index_reg inside {[IDX_OFS0:IDX_OFS3]})
                            begin
                                rd_next = ofs_reg[reg_index_reg[1:0]];
                            end
                            else if (reg_index_reg[7])
                            begin
                                rd_next  = flash_byte;
                                off_next = offset + 32'(win_k);
                            end
                            else
                            begin
                                rd_next = 8'hFF;
                            end
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    if (armed_reg)
                    begin
                        armed_next      = 1'b0;
                        cnt_next        = '0;
                        hold_valid_next = 1'b0;
                    end
                end
                CMD_RESET:
                begin
                    reg_index_next = 8'h00;
                    pending_next   = 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        ofs_next[i] = 8'h00;
                    end
                    armed_next  = 1'b0;
                    bvalid_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.emit_clear)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_CLEAR;
        end

        if (ctl.fl_rd)
        begin
            for (int l = 0; l < 4; l++)
            begin
                nib_next[l] = bvalid_reg[BUF_AW'({cnt_reg, 2'(l)})];
            end
        end

        // one word held back so the final program beat can carry last
        if (ctl.fl_chk)
        begin
            cnt_next = cnt_reg + WORD_AW'(1);
            if (flush_word != WORD_ONES)
            begin
                if (hold_valid_reg)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_PROGRAM;
                    off_next    = hold_off_reg;
                    word_next   = hold_word_reg;
                    last_next   = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_word_next  = flush_word;
                hold_off_next   = flush_addr;
            end
        end

        if (ctl.fl_end && hold_valid_reg)
        begin
            strobe_next     = 1'b1;
            kind_next       = KIND_PROGRAM;
            off_next        = hold_off_reg;
            word_next       = hold_word_reg;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_index_reg  <= 8'h00;
            pending_reg    <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                ofs_reg[i] <= 8'h00;
            end
            armed_reg      <= 1'b0;
            bvalid_reg     <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= 8'h00;
            end
        end
        else
        begin
            reg_index_reg  <= reg_index_next;
            pending_reg    <= pending_next;
            ofs_reg        <= ofs_next;
            armed_reg      <= armed_next;
            bvalid_reg     <= bvalid_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            strobe_reg     <= strobe_next;
            if (cfg_we && 32'(cfg_index) < 32'd6)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        rd_reg        <= rd_next;
        off_reg       <= off_next;
        word_reg      <= word_next;
        last_reg      <= last_next;
        hold_word_reg <= hold_word_next;
        hold_off_reg  <= hold_off_next;
        nib_reg       <= nib_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign read_data     = rd_reg;
    assign target_offset = off_reg;
    assign program_word  = word_reg;
    assign last          = last_reg;

endmodule

// ----- src/i2cfw_ctrl.sv -----
// Controller state machine: sequences the end-flag clear and the buffer flush.
// Uses i2cfw_pkg; drives i2cfw_dp through dp_cmd_t.
`timescale 1ns / 1ps

module i2cfw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  i2cfw_pkg::dp_stat_t stat,
    output i2cfw_pkg::dp_cmd_t  ctl
);
    import i2cfw_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FCHK = 3'd3;
    localparam logic [2:0] S_FEND = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (stat.go_clear)
                    begin
                        state_next = S_CLR;
                    end
                    else if (stat.go_flush)
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_CLR:
            begin
                ctl.emit_clear = 1'b1;
                state_next     = S_IDLE;
            end
            S_FRD:
            begin
                ctl.fl_rd  = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                ctl.fl_chk = 1'b1;
                state_next = stat.fl_done ? S_FEND : S_FRD;
            end
            S_FEND:
            begin
                ctl.fl_end = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && !stat.go_clear && stat.go_flush) |=> state_reg == S_FRD)
        else $error("flush did not start after armed stop");

    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fl_chk |-> $past(ctl.fl_rd))
        else $error("buffer word tested without a read");

    a_clear_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_clear |-> $past(ctl.accept))
        else $error("end-flag clear without a flash command write");

endmodule

// ----- src/i2c_register_slave_flash_window.sv -----
// Top level of the I2C register slave flash window.
// Uses i2cfw_pkg; instantiates i2cfw_ctrl and i2cfw_dp (which holds the i2cfw_ram lanes).
`timescale 1ns / 1ps

// Usage
//   Input channel: one bus event per beat (cmd, data_byte, temps, flash_byte),
//   taken at a rising edge with start high and busy low.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, indexes 6 and 7 are ignored. Write only while idle.
//   Result channel: result_strobe marks each result for exactly one cycle;
//   last is set on the final result of an event. The receiver cannot stall.
// Sequencing
//   A read byte or an unlock/lock/erase beat shows its first result in the cycle
//   after acceptance. A write to the flash command register keeps busy high
//   while in S_CLR and sends the end-flag clear through S_CLR and the result register.
//   Other events finish in the accept cycle; busy stays low, one beat a cycle.
//   An armed stop walks the buffer word by word: S_FRD reads the four byte
//   lanes, S_FCHK tests the word, and S_FEND sends the held word at the end.
//   Program results trail by one word since one is held to place last.
// Reset
//   rst_n clears the register index, offset, flush flag, buffer valid bits
//   and the config registers; unwritten buffer bytes read as zero.
module i2c_register_slave_flash_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   cmd,
    input  logic [7:0]                   data_byte,
    input  logic signed [7:0]            local_temp,
    input  logic signed [7:0]            remote_temp,
    input  logic [7:0]                   flash_byte,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [i2cfw_pkg::CFG_IW-1:0] cfg_index,
    input  logic [7:0]                   cfg_data,
    output logic                         result_strobe,
    output logic [2:0]                   kind,
    output logic [7:0]                   read_data,
    output logic [31:0]                  target_offset,
    output logic [31:0]                  program_word,
    output logic                         last
);
    import i2cfw_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // config writes never wait
    assign cfg_ready = 1'b1;

    i2cfw_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .stat (stat),
        .ctl  (ctl)
    );

    i2cfw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .local_temp   (local_temp),
        .remote_temp  (remote_temp),
        .flash_byte   (flash_byte),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_strobe(result_strobe),
        .kind         (kind),
        .read_data    (read_data),
        .target_offset(target_offset),
        .program_word (program_word),
        .last         (last)
    );

endmodule
